### rtl/ttdq_pkg.sv
// shared types and constants of the tick delay wakeup queue
`default_nettype none
package ttdq_pkg;

  localparam int unsigned MaxResults = 64;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);
  localparam logic [31:0] TickMax    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_REL   = 2'd2,
    OP_ABS   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  task_id;
    logic [31:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [31:0] wake;
    logic [7:0]  task_id;
  } entry_t;

endpackage
`default_nettype wire

### rtl/ttdq_front.sv
// request decode and two-entry command queue
`default_nettype none
module ttdq_front
  import ttdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [31:0] tick_amount_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output cmd_t             cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  // a zero relative delay is just a reply with the current count
  always_comb begin
    cmd_in.task_id = task_id_i;
    cmd_in.amount  = tick_amount_i;
    unique case (mode_i)
      OP_TICK:  cmd_in.op = OP_TICK;
      OP_QUERY: cmd_in.op = OP_QUERY;
      OP_REL:   cmd_in.op = (tick_amount_i == 32'd0) ? OP_QUERY : OP_REL;
      default:  cmd_in.op = OP_ABS;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

### rtl/ttdq_back.sv
// tick counter, sorted wait queue memory and result register
`default_nettype none
module ttdq_back
  import ttdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire cmd_t        cmd_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       reply_task_o,
  output logic [31:0]      tick_value_o,
  output logic             status_o,
  output logic             last_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_TICK_HEAD = 6'b000010,
    S_TICK_NEXT = 6'b000100,
    S_EMIT      = 6'b001000,
    S_INS_CHK   = 6'b010000,
    S_INS_PUT   = 6'b100000
  } state_e;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
    ptr_inc = (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
    ptr_dec = (a == '0) ? AW'(QUEUE_DEPTH - 1) : a - AW'(1);
  endfunction

  state_e          st_q, st_d;
  logic [31:0]     count_q, count_d;
  logic [AW-1:0]   head_q, head_d, idx_q, idx_d;
  logic [FW-1:0]   fill_q, fill_d, k_q, k_d;
  logic [NumW-1:0] n_q, n_d;
  logic [7:0]      pend_task_q, pend_task_d, task_q, task_d;
  logic            pend_status_q, pend_status_d;
  logic [31:0]     wake_q, wake_d;

  entry_t          mem [QUEUE_DEPTH];
  entry_t          rdata_q, wdata;
  logic [AW-1:0]   raddr, waddr;
  logic            we;

  logic            can_emit, out_load, out_last, more;
  logic [FW:0]     tail_sum;
  logic [AW-1:0]   tail;
  logic [32:0]     rel_sum;
  logic [31:0]     wake_new;

  assign can_emit = !out_valid_o || out_ready_i;
  assign tail_sum = (FW+1)'(head_q) + (FW+1)'(fill_q);
  assign tail     = (tail_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (FW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
  assign rel_sum  = {1'b0, count_q} + {1'b0, cmd_i.amount};
  assign wake_new = (cmd_i.op == OP_ABS) ? cmd_i.amount :
                    (rel_sum[32] ? TickMax : rel_sum[31:0]);
  assign more     = (rdata_q.wake <= count_q) && (n_q < NumW'(MaxResults));

  always_comb begin
    st_d          = st_q;
    count_d       = count_q;
    head_d        = head_q;
    idx_d         = idx_q;
    fill_d        = fill_q;
    k_d           = k_q;
    n_d           = n_q;
    pend_task_d   = pend_task_q;
    pend_status_d = pend_status_q;
    task_d        = task_q;
    wake_d        = wake_q;
    raddr         = head_q;
    waddr         = idx_q;
    wdata         = '{wake: wake_q, task_id: task_q};
    we            = 1'b0;
    cmd_ready_o   = 1'b0;
    out_load      = 1'b0;
    out_last      = 1'b1;
    unique case (st_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          pend_task_d   = cmd_i.task_id;
          pend_status_d = 1'b0;
          case (cmd_i.op)
            OP_TICK: begin
              count_d = (count_q == TickMax) ? count_q : count_q + 32'd1;
              if (fill_q != '0) begin
                st_d = S_TICK_HEAD;
              end
            end
            OP_QUERY: begin
              st_d = S_EMIT;
            end
            default: begin
              if (cmd_i.op == OP_ABS && cmd_i.amount <= count_q) begin
                st_d = S_EMIT;
              end else if (fill_q == FW'(QUEUE_DEPTH)) begin
                pend_status_d = 1'b1;
                st_d          = S_EMIT;
              end else if (fill_q == '0) begin
                we     = 1'b1;
                waddr  = head_q;
                wdata  = '{wake: wake_new, task_id: cmd_i.task_id};
                fill_d = fill_q + FW'(1);
              end else begin
                wake_d = wake_new;
                task_d = cmd_i.task_id;
                idx_d  = tail;
                k_d    = fill_q;
                raddr  = ptr_dec(tail);
                st_d   = S_INS_CHK;
              end
            end
          endcase
        end
      end
      S_TICK_HEAD: begin
        if (rdata_q.wake > count_q) begin
          st_d = S_IDLE;
        end else begin
          pend_task_d = rdata_q.task_id;
          head_d      = ptr_inc(head_q);
          fill_d      = fill_q - FW'(1);
          n_d         = NumW'(1);
          raddr       = ptr_inc(head_q);
          st_d        = (fill_q == FW'(1) || MaxResults == 1) ? S_EMIT : S_TICK_NEXT;
        end
      end
      S_TICK_NEXT: begin
        if (can_emit) begin
          out_load = 1'b1;
          out_last = !more;
          if (more) begin
            pend_task_d = rdata_q.task_id;
            head_d      = ptr_inc(head_q);
            fill_d      = fill_q - FW'(1);
            n_d         = n_q + NumW'(1);
            raddr       = ptr_inc(head_q);
            if (fill_q == FW'(1) || n_q + NumW'(1) == NumW'(MaxResults)) begin
              st_d = S_EMIT;
            end
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          out_load = 1'b1;
          st_d     = S_IDLE;
        end
      end
      S_INS_CHK: begin
        // shift larger entries one slot toward the tail
        if (rdata_q.wake > wake_q) begin
          we    = 1'b1;
          wdata = rdata_q;
          idx_d = ptr_dec(idx_q);
          k_d   = k_q - FW'(1);
          raddr = ptr_dec(ptr_dec(idx_q));
          if (k_q == FW'(1)) begin
            st_d = S_INS_PUT;
          end
        end else begin
          we     = 1'b1;
          fill_d = fill_q + FW'(1);
          st_d   = S_IDLE;
        end
      end
      S_INS_PUT: begin
        we     = 1'b1;
        fill_d = fill_q + FW'(1);
        st_d   = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    k_q           <= k_d;
    n_q           <= n_d;
    pend_task_q   <= pend_task_d;
    pend_status_q <= pend_status_d;
    task_q        <= task_d;
    wake_q        <= wake_d;
    if (out_load) begin
      reply_task_o <= pend_task_q;
      tick_value_o <= count_q;
      status_o     <= pend_status_q;
      last_o       <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/tick_delay_wakeup_queue.sv
// top level of the tick delay wakeup queue
`default_nettype none
// Tick counter with a wait queue of task ids kept sorted by wake tick. mode 0
// advances the saturating count and releases every task whose wake tick is not
// after the new count, at most 64 per tick, oldest wake tick first, ties in
// arrival order, the final one flagged with last; a tick that frees nothing
// produces no transaction. mode 1 answers with the count, mode 2 and 3 queue a
// delay or answer at once when it has already expired; a full queue answers
// with status 1. Requests go through a two-entry command queue, so the input
// side keeps taking requests while the executing side works, until both
// entries are full. An insert shifts each queued entry with a later wake tick
// toward the tail one at a time, through the single read port of the wait
// queue memory. No clearing pass after reset.
module tick_delay_wakeup_queue
  import ttdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [31:0] tick_amount_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       reply_task_o,
  output logic [31:0]      tick_value_o,
  output logic             status_o,
  output logic             last_o
);

  // decoded command between the front and back halves
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // front: decode each transaction and buffer it
  ttdq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .task_id_i     (task_id_i),
    .tick_amount_i (tick_amount_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  // back: counter, sorted queue memory and registered results
  ttdq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reply_task_o (reply_task_o),
    .tick_value_o (tick_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
